FILE: rtl/core/pbnc_pkg.sv
`timescale 1ns / 1ps
// Shared types, register indexes and helpers of the palette builder.
package pbnc_pkg;

  localparam int COLOR_W = 8;
  localparam int LIMIT_W = 9;
  localparam int THR_W   = 18;
  localparam int DIST_W  = 18;
  localparam int IDX8_W  = 8;

  localparam logic CFG_COLOR_LIMIT = 1'b0;
  localparam logic CFG_MERGE_THR   = 1'b1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_READ   = 2'd2,
    MODE_CLEAR  = 2'd3
  } pbnc_mode_t;

  typedef struct packed {
    pbnc_mode_t          mode;
    logic [COLOR_W-1:0]  red;
    logic [COLOR_W-1:0]  green;
    logic [COLOR_W-1:0]  blue;
    logic [IDX8_W-1:0]   entry_index;
    logic                exact_hit;
    logic [IDX8_W-1:0]   exact_idx;
    logic                merge_hit;
    logic                near_hit;
    logic [DIST_W-1:0]   best_dist;
    logic [IDX8_W-1:0]   near_idx;
    logic [COLOR_W-1:0]  rd_red;
    logic [COLOR_W-1:0]  rd_green;
    logic [COLOR_W-1:0]  rd_blue;
  } pbnc_tok_t;

  function automatic logic [2*COLOR_W-1:0] sq_diff(input logic [COLOR_W-1:0] a,
                                                   input logic [COLOR_W-1:0] b);
    logic [COLOR_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return {{COLOR_W{1'b0}}, d} * {{COLOR_W{1'b0}}, d};
  endfunction

endpackage

FILE: rtl/core/pbnc_in_if.sv
`timescale 1ns / 1ps
// Input channel of the palette builder: command beats with color and index.
interface pbnc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] entry_index;

  modport source (output valid, mode, red_in, green_in, blue_in, entry_index,
                  input ready);
  modport sink   (input valid, mode, red_in, green_in, blue_in, entry_index,
                  output ready);
endinterface

FILE: rtl/core/pbnc_out_if.sv
`timescale 1ns / 1ps
// Result channel of the palette builder: one result beat per command.
interface pbnc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] match_index;
  logic       match_valid;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [8:0] entries_used;
  logic       overflow_error;

  modport source (output valid, match_index, match_valid, red_out, green_out,
                  blue_out, entries_used, overflow_error, input ready);
  modport sink   (input valid, match_index, match_valid, red_out, green_out,
                  blue_out, entries_used, overflow_error, output ready);
endinterface

FILE: rtl/core/pbnc_cell.sv
`timescale 1ns / 1ps
// One palette cell: holds an entry and updates the passing search token.
module pbnc_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 9
) (
  input  logic                              clk,
  input  pbnc_pkg::pbnc_tok_t               tok_i,
  output pbnc_pkg::pbnc_tok_t               tok_o,
  input  logic [CNT_W-1:0]                  count,
  input  logic [pbnc_pkg::THR_W-1:0]        threshold,
  input  logic                              wr_en,
  input  logic [3*pbnc_pkg::COLOR_W-1:0]    wr_color
);
  import pbnc_pkg::*;

  localparam logic [CNT_W-1:0]  MY_IDX   = CNT_W'(IDX);
  localparam logic [IDX8_W-1:0] SHORT_IDX = IDX8_W'(IDX);
  localparam bit                READABLE = (IDX < 256);

  logic [3*COLOR_W-1:0] entry_r;
  pbnc_tok_t            tok_r;
  pbnc_tok_t            tok_nxt;
  logic [DIST_W-1:0]    sq_dist;
  logic                 live;

  always_comb begin
    sq_dist = DIST_W'(sq_diff(entry_r[23:16], tok_i.red))
            + DIST_W'(sq_diff(entry_r[15:8], tok_i.green))
            + DIST_W'(sq_diff(entry_r[7:0], tok_i.blue));
    live = count > MY_IDX;
    tok_nxt = tok_i;
    if (live) begin
      if (!tok_i.exact_hit && entry_r == {tok_i.red, tok_i.green, tok_i.blue}) begin
        tok_nxt.exact_hit = 1'b1;
        tok_nxt.exact_idx = SHORT_IDX;
      end
      if (threshold > sq_dist) begin
        tok_nxt.merge_hit = 1'b1;
      end
      if (!tok_i.near_hit || sq_dist < tok_i.best_dist) begin
        tok_nxt.near_hit  = 1'b1;
        tok_nxt.best_dist = sq_dist;
        tok_nxt.near_idx  = SHORT_IDX;
      end
      if (READABLE && tok_i.entry_index == SHORT_IDX) begin
        tok_nxt.rd_red   = entry_r[23:16];
        tok_nxt.rd_green = entry_r[15:8];
        tok_nxt.rd_blue  = entry_r[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
    if (wr_en && count == MY_IDX) begin
      entry_r <= wr_color;
    end
  end

  assign tok_o = tok_r;

endmodule

FILE: rtl/core/palette_builder_nearest_color.sv
`timescale 1ns / 1ps
// Palette builder with nearest-color lookup, built as a chain of entry cells.
// Only one command is in flight: a new beat is accepted only once the previous
// result has been committed; the search token walks the cell chain one cell
// per cycle and the palette is updated at the end.
// Reset (synchronous, active low) empties the palette, clears the overflow
// flag and restores color_limit to 256 and merge_threshold to 0.
module palette_builder_nearest_color #(
  parameter int PALETTE_SIZE = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  pbnc_in_if.sink                      in_ch,
  pbnc_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [pbnc_pkg::THR_W-1:0]   cfg_wdata
);
  import pbnc_pkg::*;

  localparam int CNT_W = $clog2(PALETTE_SIZE + 1);
  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(PALETTE_SIZE);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t               state_r;
  logic [CNT_W-1:0]     step_r;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic                 full_r;
  logic                 full_nxt;
  logic [LIMIT_W-1:0]   limit_r;
  logic [THR_W-1:0]     thr_r;
  pbnc_tok_t            head_r;
  pbnc_tok_t            tok_w [0:PALETTE_SIZE];
  pbnc_tok_t            tail;

  logic                 out_valid_r;
  logic [7:0]           out_match_r;
  logic                 out_mvalid_r;
  logic [7:0]           out_red_r;
  logic [7:0]           out_green_r;
  logic [7:0]           out_blue_r;
  logic [8:0]           out_used_r;
  logic                 out_ovf_r;

  logic                 commit;
  logic                 add_ok;
  logic                 room;
  logic                 merging;
  logic [7:0]           m_idx;
  logic                 m_val;
  logic [7:0]           rd_red;
  logic [7:0]           rd_green;
  logic [7:0]           rd_blue;

  assign tok_w[0] = head_r;
  assign tail     = tok_w[PALETTE_SIZE];

  for (genvar i = 0; i < PALETTE_SIZE; i++) begin : g_cell
    pbnc_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .tok_i     (tok_w[i]),
      .tok_o     (tok_w[i+1]),
      .count     (count_r),
      .threshold (thr_r),
      .wr_en     (add_ok),
      .wr_color  ({tail.red, tail.green, tail.blue})
    );
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign merging     = (thr_r != '0);
  assign room        = (CMP_W'(count_r) < CMP_W'(limit_r)) && (count_r < LAST);
  assign commit      = (state_r == S_SCAN) && (step_r == LAST)
                    && (!out_valid_r || out_ch.ready);

  always_comb begin
    count_nxt = count_r;
    full_nxt  = full_r;
    add_ok    = 1'b0;
    m_idx     = '0;
    m_val     = 1'b1;
    rd_red    = '0;
    rd_green  = '0;
    rd_blue   = '0;
    unique case (tail.mode)
      MODE_ADD: begin
        if (!full_r && !tail.exact_hit && !tail.merge_hit) begin
          if (room) begin
            add_ok    = commit;
            count_nxt = count_r + 1'b1;
          end else begin
            full_nxt = 1'b1;
          end
        end
      end
      MODE_LOOKUP: begin
        if (tail.exact_hit) begin
          m_idx = tail.exact_idx;
        end else if (merging) begin
          m_val = tail.near_hit;
          m_idx = tail.near_hit ? tail.near_idx : '0;
        end
      end
      MODE_READ: begin
        rd_red   = tail.rd_red;
        rd_green = tail.rd_green;
        rd_blue  = tail.rd_blue;
      end
      MODE_CLEAR: begin
        count_nxt = '0;
        full_nxt  = 1'b0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      count_r     <= '0;
      full_r      <= 1'b0;
      limit_r     <= LIMIT_RESET;
      thr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_COLOR_LIMIT: limit_r <= cfg_wdata[LIMIT_W-1:0];
          CFG_MERGE_THR:   thr_r   <= cfg_wdata;
          default:         thr_r   <= thr_r;
        endcase
      end
      if (out_valid_r && out_ch.ready && !commit) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            state_r <= S_SCAN;
            step_r  <= '0;
          end
        end
        S_SCAN: begin
          if (step_r != LAST) begin
            step_r <= step_r + 1'b1;
          end
          if (commit) begin
            state_r     <= S_IDLE;
            count_r     <= count_nxt;
            full_r      <= full_nxt;
            out_valid_r <= 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      head_r.mode        <= pbnc_mode_t'(in_ch.mode);
      head_r.red         <= in_ch.red_in;
      head_r.green       <= in_ch.green_in;
      head_r.blue        <= in_ch.blue_in;
      head_r.entry_index <= in_ch.entry_index;
      head_r.exact_hit   <= 1'b0;
      head_r.exact_idx   <= '0;
      head_r.merge_hit   <= 1'b0;
      head_r.near_hit    <= 1'b0;
      head_r.best_dist   <= '0;
      head_r.near_idx    <= '0;
      head_r.rd_red      <= '0;
      head_r.rd_green    <= '0;
      head_r.rd_blue     <= '0;
    end
    if (commit) begin
      out_match_r  <= m_idx;
      out_mvalid_r <= m_val;
      out_red_r    <= rd_red;
      out_green_r  <= rd_green;
      out_blue_r   <= rd_blue;
      out_used_r   <= 9'(count_nxt);
      out_ovf_r    <= full_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.match_index    = out_match_r;
  assign out_ch.match_valid    = out_mvalid_r;
  assign out_ch.red_out        = out_red_r;
  assign out_ch.green_out      = out_green_r;
  assign out_ch.blue_out       = out_blue_r;
  assign out_ch.entries_used   = out_used_r;
  assign out_ch.overflow_error = out_ovf_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LAST)
    else $error("entry count exceeds palette size");

  a_count_stable_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) && $past(state_r == S_SCAN) |-> $stable(count_r))
    else $error("entry count changed during a scan");

  a_result_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_SCAN && step_r == LAST))
    else $error("result beat raised before the scan ended");

  a_overflow_no_add: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(full_r) |-> $stable(count_r))
    else $error("overflow set while the count moved");
`endif

endmodule

FILE: test/palette_builder_nearest_color_checker.sv
`timescale 1ns / 1ps
// Checker for the palette builder: mirrors the palette and compares every result beat.
module palette_builder_nearest_color_checker #(
  parameter int PALETTE_SIZE = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  pbnc_in_if                         in_ch,
  pbnc_out_if                        out_ch,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [pbnc_pkg::THR_W-1:0] cfg_wdata,
  output int                         mismatch_count,
  output int                         beats_due
);
  import pbnc_pkg::*;

  localparam int FAR_DISTANCE = 10000000;

  typedef struct packed {
    logic [7:0] match_index;
    logic       match_valid;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [8:0] entries_used;
    logic       overflow_error;
  } palette_reply_t;

  logic [23:0]        colors [PALETTE_SIZE];
  int                 stored;
  logic               overflowed;
  logic [LIMIT_W-1:0] limit_reg;
  logic [THR_W-1:0]   threshold_reg;
  palette_reply_t     replies_due [$];
  int                 errors = 0;
  int                 due = 0;

  assign mismatch_count = errors;
  assign beats_due = due;

  task automatic flag_error(string msg);
    $display("%0t ns: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int color_distance(logic [23:0] a, logic [23:0] b);
    int sum;
    int d;
    sum = 0;
    for (int c = 0; c < 3; c++) begin
      d = int'(a[8*c +: 8]) - int'(b[8*c +: 8]);
      sum += d * d;
    end
    return sum;
  endfunction

  function automatic int find_color(logic [23:0] rgb);
    for (int i = 0; i < stored; i++)
      if (colors[i] == rgb) return i;
    return -1;
  endfunction

  function automatic palette_reply_t apply_command(pbnc_mode_t mode, logic [23:0] rgb,
                                                   logic [7:0] idx);
    palette_reply_t reply;
    int hit;
    int best;
    int entry_gap;
    int cap;
    bit merged;
    reply = '0;
    reply.match_valid = 1'b1;
    hit = find_color(rgb);
    case (mode)
      MODE_ADD: begin
        if (!overflowed && hit < 0) begin
          merged = 1'b0;
          if (threshold_reg != 0)
            for (int i = 0; i < stored; i++)
              if (color_distance(colors[i], rgb) < threshold_reg) merged = 1'b1;
          if (!merged) begin
            cap = (limit_reg > PALETTE_SIZE) ? PALETTE_SIZE : int'(limit_reg);
            if (stored < cap) begin
              colors[stored] = rgb;
              stored++;
            end else begin
              overflowed = 1'b1;
            end
          end
        end
      end
      MODE_LOOKUP: begin
        if (hit >= 0) begin
          reply.match_index = hit[7:0];
        end else if (threshold_reg != 0) begin
          best = FAR_DISTANCE;
          reply.match_valid = 1'b0;
          for (int i = 0; i < stored; i++) begin
            entry_gap = color_distance(colors[i], rgb);
            if (entry_gap < best) begin
              best = entry_gap;
              reply.match_index = i[7:0];
              reply.match_valid = 1'b1;
            end
          end
        end
      end
      MODE_READ: begin
        if (idx < stored) {reply.red, reply.green, reply.blue} = colors[idx];
      end
      default: begin
        stored = 0;
        overflowed = 1'b0;
      end
    endcase
    reply.entries_used = stored[8:0];
    reply.overflow_error = overflowed;
    return reply;
  endfunction

  task automatic compare_reply(palette_reply_t got, palette_reply_t want);
    if (got.match_index !== want.match_index)
      flag_error($sformatf("match_index got %0d, expected %0d",
                           got.match_index, want.match_index));
    if (got.match_valid !== want.match_valid)
      flag_error($sformatf("match_valid got %0b, expected %0b",
                           got.match_valid, want.match_valid));
    if (got.red !== want.red)
      flag_error($sformatf("red_out got %0d, expected %0d", got.red, want.red));
    if (got.green !== want.green)
      flag_error($sformatf("green_out got %0d, expected %0d", got.green, want.green));
    if (got.blue !== want.blue)
      flag_error($sformatf("blue_out got %0d, expected %0d", got.blue, want.blue));
    if (got.entries_used !== want.entries_used)
      flag_error($sformatf("entries_used got %0d, expected %0d",
                           got.entries_used, want.entries_used));
    if (got.overflow_error !== want.overflow_error)
      flag_error($sformatf("overflow_error got %0b, expected %0b",
                           got.overflow_error, want.overflow_error));
  endtask

  always @(posedge clk) begin
    palette_reply_t got;
    if (!rst_n) begin
      stored = 0;
      overflowed = 1'b0;
      limit_reg = LIMIT_RESET;
      threshold_reg = '0;
      replies_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_COLOR_LIMIT) limit_reg = cfg_wdata[LIMIT_W-1:0];
        else threshold_reg = cfg_wdata;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{match_index: out_ch.match_index, match_valid: out_ch.match_valid,
                red: out_ch.red_out, green: out_ch.green_out, blue: out_ch.blue_out,
                entries_used: out_ch.entries_used, overflow_error: out_ch.overflow_error};
        if (replies_due.size() == 0) flag_error("result beat with no command waiting");
        else compare_reply(got, replies_due.pop_front());
      end
      if (in_ch.valid && in_ch.ready)
        replies_due.push_back(apply_command(pbnc_mode_t'(in_ch.mode),
                                            {in_ch.red_in, in_ch.green_in, in_ch.blue_in},
                                            in_ch.entry_index));
    end
    due <= replies_due.size();
  end

endmodule

FILE: test/palette_builder_nearest_color_test.sv
`timescale 1ns / 1ps
// Testbench top for the palette builder: stimulus, flow control and the final verdict.
module palette_builder_nearest_color_test;
  import pbnc_pkg::*;

  localparam int PALETTE_SIZE  = 256;
  localparam int MAX_THRESHOLD = 195076;
  localparam int STALL_LIMIT   = 5000;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_index;
  logic [THR_W-1:0] cfg_wdata;
  int               send_idle_pct;
  int               recv_idle_pct;
  int               quiet_cycles = 0;
  int               mismatches;
  int               beats_due;
  logic [23:0]      color_pool [16];

  pbnc_in_if  in_ch ();
  pbnc_out_if out_ch ();

  palette_builder_nearest_color #(
    .PALETTE_SIZE(PALETTE_SIZE)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  palette_builder_nearest_color_checker #(
    .PALETTE_SIZE(PALETTE_SIZE)
  ) u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .mismatch_count(mismatches),
    .beats_due     (beats_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_command(pbnc_mode_t mode, logic [23:0] rgb, logic [7:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    {in_ch.red_in, in_ch.green_in, in_ch.blue_in} <= rgb;
    in_ch.entry_index <= idx;
    if (mode == MODE_ADD) color_pool[$urandom_range(15)] = rgb;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (beats_due != 0) @(posedge clk);
  endtask

  task automatic set_config(int limit, int threshold);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_COLOR_LIMIT;
    cfg_wdata <= THR_W'(limit);
    @(posedge clk);
    cfg_index <= CFG_MERGE_THR;
    cfg_wdata <= THR_W'(threshold);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Reuse recent colors or near neighbors of them in part of the picks so that exact
  // hits and merges happen often enough.
  function automatic logic [23:0] next_color(int pool_pct);
    logic [23:0] base;
    int pick;
    pick = $urandom_range(99);
    base = color_pool[$urandom_range(15)];
    if (pick < pool_pct) return base;
    if (pick < pool_pct + 15) return base ^ (24'($urandom()) & 24'h070707);
    return 24'($urandom());
  endfunction

  task automatic run_segment(int limit, int threshold, int count, int clear_pct, int add_pct,
                             int pool_pct);
    int pick;
    pbnc_mode_t mode;
    logic [7:0] idx;
    set_config(limit, threshold);
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < clear_pct) mode = MODE_CLEAR;
      else if (pick < clear_pct + add_pct) mode = MODE_ADD;
      else if ($urandom_range(9) < 6) mode = MODE_LOOKUP;
      else mode = MODE_READ;
      idx = $urandom_range(1) ? 8'($urandom()) : 8'($urandom_range(20));
      send_command(mode, next_color(pool_pct), idx);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_ADD;
    in_ch.red_in = '0;
    in_ch.green_in = '0;
    in_ch.blue_in = '0;
    in_ch.entry_index = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_COLOR_LIMIT;
    cfg_wdata = '0;
    foreach (color_pool[i]) color_pool[i] = 24'($urandom());
    send_idle_pct = 11;
    recv_idle_pct = 72;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Small limit, merging off: duplicates, filling up, sticky overflow.
    set_config(4, 0);
    send_command(MODE_LOOKUP, 24'h123456, 8'd0);
    send_command(MODE_READ,   24'h000000, 8'd0);
    send_command(MODE_ADD,    24'h000000, 8'd0);
    send_command(MODE_ADD,    24'hFFFFFF, 8'hFF);
    send_command(MODE_ADD,    24'h000000, 8'd0);
    send_command(MODE_ADD,    24'hAA55AA, 8'hAA);
    send_command(MODE_ADD,    24'h55AA55, 8'h55);
    send_command(MODE_ADD,    24'h010203, 8'd0);
    send_command(MODE_ADD,    24'h020304, 8'd0);
    send_command(MODE_LOOKUP, 24'hFFFFFF, 8'd0);
    send_command(MODE_LOOKUP, 24'h808080, 8'd0);
    send_command(MODE_READ,   24'h000000, 8'd3);
    send_command(MODE_READ,   24'h000000, 8'd255);

    // Limit above the palette size and the largest threshold; palette is kept.
    set_config(511, MAX_THRESHOLD);
    send_command(MODE_LOOKUP, 24'h7F7F7F, 8'd0);
    send_command(MODE_CLEAR,  24'h000000, 8'd0);
    send_command(MODE_LOOKUP, 24'h101010, 8'd0);
    send_command(MODE_ADD,    24'h000000, 8'd0);
    send_command(MODE_ADD,    24'h020000, 8'd0);

    // Tight threshold: a close color merges, a farther one is stored, ties pick the
    // lower entry.
    set_config(16, 5);
    send_command(MODE_ADD,    24'h020000, 8'd0);
    send_command(MODE_ADD,    24'h040000, 8'd0);
    send_command(MODE_LOOKUP, 24'h020000, 8'd0);
    send_command(MODE_LOOKUP, 24'h030000, 8'd0);

    // A zero limit overflows on the first add.
    set_config(0, 0);
    send_command(MODE_CLEAR,  24'h000000, 8'd0);
    send_command(MODE_ADD,    24'h112233, 8'd0);
    send_command(MODE_READ,   24'h000000, 8'd0);

    run_segment(511, 0, 340, 0, 90, 5);
    run_segment(16, 3000, 90, 8, 50, 40);

    send_idle_pct = 72;
    recv_idle_pct = 11;
    run_segment(0, MAX_THRESHOLD, 60, 5, 40, 40);
    run_segment(5, 30000, 120, 6, 50, 40);
    run_segment(1, 1, 60, 5, 50, 40);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_segment($urandom_range(256), $urandom_range(MAX_THRESHOLD), 100, 4, 45, 30);
    run_segment(2, 50, 80, 5, 50, 40);

    wait_idle();
    repeat (PALETTE_SIZE + 10) @(posedge clk);
    if (mismatches == 0 && beats_due == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/pbnc_pkg.sv
rtl/core/pbnc_in_if.sv
rtl/core/pbnc_out_if.sv
rtl/core/pbnc_cell.sv
rtl/core/palette_builder_nearest_color.sv
test/palette_builder_nearest_color_checker.sv
test/palette_builder_nearest_color_test.sv
